### rtl/atm_pkg.sv
// shared constants and types for the atmosphere table interpolator
`default_nettype none
package atm_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ROWS_W      = 7;
  localparam int N_W         = (CNT_W > ROWS_W) ? CNT_W : ROWS_W;
  localparam int DATA_W      = 32;
  localparam int QTY_N       = 4;
  localparam int ROW_W       = DATA_W * QTY_N;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] v0;
    logic [DATA_W-1:0] v1;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } lerp_req_t;
endpackage
`default_nettype wire

### rtl/atm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module atm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/atm_lerp_lane.sv
// one interpolation lane: multiply then bit-serial restoring divide
`default_nettype none
module atm_lerp_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire atm_pkg::lerp_req_t req,
  output logic                    done,
  output logic [atm_pkg::DATA_W-1:0] result
);
  import atm_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_FIN  = 2'd3;
  localparam int CW = $clog2(DATA_W);

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                neg_r;
  logic [DATA_W-1:0]   v0_r, d_r, num_r, den_r, rem_r, lo_r, q_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [DATA_W:0]     trial;
  logic [DATA_W:0]     diff;
  logic                ge;
  logic                first_step;

  // first divide step starts from the product high half and its next bit
  assign first_step = cnt_r == CW'(DATA_W - 1);
  assign trial = first_step ? {prod_r[2*DATA_W-1:DATA_W], prod_r[DATA_W-1]}
                            : {rem_r, lo_r[DATA_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      L_IDLE: if (req.start) state_nxt = L_MUL;
      L_MUL: begin
        state_nxt = L_DIV;
        cnt_nxt   = CW'(DATA_W - 1);
      end
      L_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = L_FIN;
      end
      L_FIN: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && req.start) begin
      neg_r <= req.v1 < req.v0;
      d_r   <= (req.v1 < req.v0) ? req.v0 - req.v1 : req.v1 - req.v0;
      v0_r  <= req.v0;
      num_r <= req.num;
      den_r <= req.den;
    end
    if (state_r == L_MUL) begin
      prod_r <= (2*DATA_W)'(d_r) * (2*DATA_W)'(num_r);
    end
    // product high half is below den, so the quotient fits one word
    if (state_r == L_DIV && first_step) begin
      rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_r  <= {prod_r[DATA_W-2:0], 1'b0};
      q_r   <= {{(DATA_W-1){1'b0}}, ge};
    end else if (state_r == L_DIV) begin
      rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_r  <= {lo_r[DATA_W-2:0], 1'b0};
      q_r   <= {q_r[DATA_W-2:0], ge};
    end
  end

  assign done   = state_r == L_FIN;
  assign result = neg_r ? v0_r - q_r : v0_r + q_r;
endmodule
`default_nettype wire

### rtl/atmosphere_table_interpolator_top.sv
// atmosphere table interpolator top level: row storage, search and result
//
// channel | ports                              | transfer
// input   | start, busy, in_*                  | start high while busy low
// result  | out_valid, out_*                   | out_valid high for one cycle
// config  | cfg_we, cfg_wdata                  | cfg_we high
//
// a load transfer writes one row in the cycle it is taken; busy stays low
// a query walks the altitude ram one row at a time (read, compare), fetches the
// two bracketing rows (lower address, lower data, upper data), then waits on four
// lerp lanes in parallel (multiply, 32-step divide, finish); a query off either
// end of the table returns the edge row without the lanes; an empty table keeps
// busy low; the strobe comes once busy is low again; synchronous reset clears
// control state only; the receiver cannot stall
`default_nettype none
module atmosphere_table_interpolator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [5:0]  in_row_index,
  input  wire logic signed [31:0] in_row_altitude,
  input  wire logic [31:0] in_row_temperature,
  input  wire logic [31:0] in_row_gravity,
  input  wire logic [31:0] in_row_pressure,
  input  wire logic [31:0] in_row_density,
  input  wire logic signed [31:0] in_query_altitude,
  output logic             out_valid,
  output logic [31:0]      out_temperature_out,
  output logic [31:0]      out_gravity_out,
  output logic [31:0]      out_pressure_out,
  output logic [31:0]      out_density_out,
  output logic             out_out_of_range,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);
  import atm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // altitude read in flight
  localparam logic [3:0] S_CMP  = 4'd2;  // compare altitude with query
  localparam logic [3:0] S_Q0   = 4'd3;  // lower row address presented
  localparam logic [3:0] S_Q1   = 4'd4;  // lower row data back
  localparam logic [3:0] S_Q2   = 4'd5;  // upper row data back, lanes start
  localparam logic [3:0] S_LRP  = 4'd6;  // waiting on lanes
  localparam logic [3:0] S_EDGE = 4'd7;  // end row address presented
  localparam logic [3:0] S_EOUT = 4'd8;  // end row data back

  logic [3:0]         state_r, state_nxt;
  logic [ROWS_W-1:0]  rows_r;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   qaddr_r, qaddr_nxt;
  logic signed [DATA_W-1:0] h_r, prev_r, h1_r;
  logic [ROW_W-1:0]   v0_r;
  logic [ROW_W-1:0]   q_rdata;
  logic [DATA_W-1:0]  alt_rdata;
  logic               accept, wr_en, found;
  logic [IDX_W-1:0]   waddr;
  logic [N_W-1:0]     rows_ext;
  logic [QTY_N-1:0]   lane_done;
  logic [DATA_W-1:0]  lane_res [QTY_N];
  lerp_req_t          lane_req [QTY_N];

  logic               out_valid_r, out_valid_nxt;
  logic               oor_r;
  logic [DATA_W-1:0]  res_r [QTY_N];

  assign accept   = start && !busy;
  assign busy     = state_r != S_IDLE;
  assign waddr    = IDX_W'(in_row_index);
  // rows past the table are dropped on load
  assign wr_en    = accept && !in_kind && (N_W'(in_row_index) < N_W'(TABLE_DEPTH));
  assign rows_ext = N_W'(rows_r);
  assign found    = $signed(alt_rdata) > h_r;

  atm_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_alt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (in_row_altitude),
    .raddr (idx_r),
    .rdata (alt_rdata)
  );

  // quantity columns side by side: temperature in the low word
  atm_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_qty_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata ({in_row_density, in_row_pressure, in_row_gravity, in_row_temperature}),
    .raddr (qaddr_r),
    .rdata (q_rdata)
  );

  for (genvar k = 0; k < QTY_N; k++) begin : g_lane
    assign lane_req[k].start = state_r == S_Q2;
    assign lane_req[k].v0    = v0_r[k*DATA_W +: DATA_W];
    assign lane_req[k].v1    = q_rdata[k*DATA_W +: DATA_W];
    // h0 <= h < h1, so both differences fit unsigned in one word
    assign lane_req[k].num   = h_r - prev_r;
    assign lane_req[k].den   = h1_r - prev_r;

    atm_lerp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .req    (lane_req[k]),
      .done   (lane_done[k]),
      .result (lane_res[k])
    );
  end

  // search and fetch sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    qaddr_nxt     = qaddr_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_kind) begin
          n_nxt   = (rows_ext > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : rows_ext;
          idx_nxt = '0;
          if (rows_ext == '0) begin
            out_valid_nxt = 1'b1;  // empty table answers at once
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:  state_nxt = S_CMP;
      S_CMP: begin
        if (found && idx_r == '0) begin
          qaddr_nxt = '0;          // below the first row
          state_nxt = S_EDGE;
        end else if (found) begin
          qaddr_nxt = idx_r - 1'b1;
          state_nxt = S_Q0;
        end else if (N_W'(idx_r) == n_r - 1'b1) begin
          qaddr_nxt = idx_r;       // at or above the last row
          state_nxt = S_EDGE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_Q0: begin
        qaddr_nxt = idx_r;
        state_nxt = S_Q1;
      end
      S_Q1:  state_nxt = S_Q2;
      S_Q2:  state_nxt = S_LRP;
      S_LRP: begin
        if (&lane_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EDGE: state_nxt = S_EOUT;
      S_EOUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
      qaddr_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      qaddr_r     <= qaddr_nxt;
      if (cfg_we) begin
        rows_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && in_kind) begin
      h_r <= in_query_altitude;
    end
    if (state_r == S_CMP) begin
      if (found) begin
        h1_r <= $signed(alt_rdata);
      end else begin
        prev_r <= $signed(alt_rdata);
      end
    end
    if (state_r == S_Q1) begin
      v0_r <= q_rdata;
    end
    for (int k = 0; k < QTY_N; k++) begin
      if (state_r == S_IDLE && accept && in_kind) begin
        res_r[k] <= '0;
      end else if (state_r == S_LRP) begin
        res_r[k] <= lane_res[k];
      end else if (state_r == S_EOUT) begin
        res_r[k] <= q_rdata[k*DATA_W +: DATA_W];
      end
    end
    if (state_r == S_IDLE && accept && in_kind) begin
      oor_r <= 1'b1;
    end else if (state_r == S_LRP) begin
      oor_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_out = res_r[0];
  assign out_gravity_out     = res_r[1];
  assign out_pressure_out    = res_r[2];
  assign out_density_out     = res_r[3];
  assign out_out_of_range    = oor_r;

  // a result only appears once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE)) else $error("result strobe while busy");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_kind) |=> !out_valid) else $error("load produced a result");

  // the search index stays inside the searched rows
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (N_W'(idx_r) < n_r)) else $error("search index out of range");

  // lanes only finish while the sequencer waits on them
  a_lane_done: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (state_r == S_LRP)) else $error("lane finished out of turn");
endmodule
`default_nettype wire
